FILE: rtl/rxq_pkg.sv
// Shared field widths and opcodes for the range XOR update and query unit.
`timescale 1ns / 1ps
`default_nettype none
package rxq_pkg;
  localparam int IDX_BITS  = 10;
  localparam int DATA_BITS = 32;
  localparam int CNT_BITS  = 11;
  localparam int WIDE_BITS = 21;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [DATA_BITS-1:0] data_t;
endpackage
`default_nettype wire

FILE: rtl/range_xor_update_query_tree_unit.sv
// Top level: sequencer walking two binary indexed trees kept in one RAM.
//
//  channel | direction | handshake              | word contents
//  in_     | slave     | in_tvalid / in_tready   | opcode, range_low, range_high, xor_value
//  out_    | master    | out_tvalid / out_tready | query_xor, range_error
//  cfg_    | slave     | cfg_valid / cfg_ready   | active_count
//
// An update costs one or two point updates of up to log2(MAX_ELEMENTS)+1 steps,
// each step a read state and a write state on the single RAM port; a query
// costs one or two prefix walks of a read and an accumulate state per step.
// After reset the RAM, 2*2^clog2(MAX_ELEMENTS+1) words (4096 by default), is
// swept to zero, one word a cycle, before in_tready rises.
// A finished query waits in the output register while the next word is taken.
//
// The element array is stored as difference words d[j], with an update XORing
// its value into d[low] and d[high+1]. Element i is the XOR of d[0..i], so the
// XOR of elements 0..x is the XOR of d[j] for j <= x with j of the same parity
// as x. One Fenwick tree per parity class gives that sum, and a range answer
// is the prefix at high XOR the prefix at low-1.
`timescale 1ns / 1ps
`default_nettype none
module range_xor_update_query_tree_unit #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [0] opcode, [10:1] range_low, [20:11] range_high, [52:21] xor_value
  input  wire  [55:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [31:0] query_xor, [32] range_error
  output logic [39:0] out_tdata,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [10:0] cfg_data
);
  localparam int IW = $clog2(MAX_ELEMENTS + 1);
  localparam int FW = IW + 1;
  localparam int AW = IW + 1;
  localparam int WB = rxq_pkg::WIDE_BITS;
  localparam logic [WB-1:0] MAX_W = WB'(MAX_ELEMENTS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_URD  = 3'd2;
  localparam logic [2:0] S_UWR  = 3'd3;
  localparam logic [2:0] S_QRD  = 3'd4;
  localparam logic [2:0] S_QACC = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [10:0] count_r;
  rxq_pkg::idx_t lo_r, lo_nxt, hi_r, hi_nxt;
  rxq_pkg::data_t w_r, w_nxt, acc_r, acc_nxt;
  logic        err_r, err_nxt;
  logic        pass_r, pass_nxt;
  logic        par_r, par_nxt;
  logic [FW-1:0] f_r, f_nxt, f_low;
  logic [AW-1:0] clr_r, clr_nxt;
  logic        out_valid_r, out_valid_nxt;
  rxq_pkg::data_t out_xor_r, out_xor_nxt;
  logic        out_err_r, out_err_nxt;

  logic        ram_we;
  logic [AW-1:0] ram_addr;
  rxq_pkg::data_t ram_wdata, ram_rdata;

  logic        in_fire;
  logic        in_op;
  rxq_pkg::idx_t in_lo, in_hi;
  logic [WB-1:0] cnt_eff, in_hi_w, hi_w, lo_w;
  logic        in_bad;

  assign in_op = in_tdata[0];
  assign in_lo = in_tdata[10:1];
  assign in_hi = in_tdata[20:11];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_err_r, out_xor_r};

  // The effective count never exceeds the tree capacity.
  assign cnt_eff = (WB'(count_r) > MAX_W) ? MAX_W : WB'(count_r);
  assign in_hi_w = WB'(in_hi);
  assign in_bad  = (in_lo > in_hi) || (in_hi_w >= cnt_eff);
  assign hi_w    = WB'(hi_r);
  assign lo_w    = WB'(lo_r);

  // Lowest set bit of the Fenwick index.
  assign f_low = f_r & (~f_r + FW'(1));

  rxq_ram #(.ADDR_BITS(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    w_nxt         = w_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    pass_nxt      = pass_r;
    par_nxt       = par_r;
    f_nxt         = f_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_xor_nxt   = out_xor_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_addr      = {par_r, f_r[IW-1:0]};
    ram_wdata     = ram_rdata ^ w_r;

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          lo_nxt   = in_lo;
          hi_nxt   = in_hi;
          w_nxt    = in_tdata[52:21];
          acc_nxt  = '0;
          err_nxt  = in_bad;
          pass_nxt = 1'b0;
          if (in_op == rxq_pkg::OP_UPDATE) begin
            // First point: d[low], Fenwick index low+1.
            f_nxt   = FW'(WB'(in_lo) + WB'(1));
            par_nxt = in_lo[0];
            state_nxt = in_bad ? S_IDLE : S_URD;
          end else begin
            // First prefix: elements up to high.
            f_nxt   = FW'(in_hi_w + WB'(1));
            par_nxt = in_hi[0];
            state_nxt = in_bad ? S_DONE : S_QRD;
          end
        end
      end
      S_URD: begin
        if (WB'(f_r) > MAX_W) begin
          // Walk finished; the second point is d[high+1] when it exists.
          if (!pass_r && (hi_w + WB'(1) < MAX_W)) begin
            pass_nxt = 1'b1;
            f_nxt    = FW'(hi_w + WB'(2));
            par_nxt  = ~hi_r[0];
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_UWR;
        end
      end
      S_UWR: begin
        ram_we    = 1'b1;
        f_nxt     = f_r + f_low;
        state_nxt = S_URD;
      end
      S_QRD: begin
        if (f_r == '0) begin
          // Second prefix covers elements up to low-1, absent when low is zero.
          if (!pass_r && (lo_r != '0)) begin
            pass_nxt = 1'b1;
            f_nxt    = FW'(lo_w);
            par_nxt  = ~lo_r[0];
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_QACC;
        end
      end
      S_QACC: begin
        acc_nxt   = acc_r ^ ram_rdata;
        f_nxt     = f_r - f_low;
        state_nxt = S_QRD;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_xor_nxt   = acc_r;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      count_r     <= 11'd1024;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    w_r       <= w_nxt;
    acc_r     <= acc_nxt;
    err_r     <= err_nxt;
    pass_r    <= pass_nxt;
    par_r     <= par_nxt;
    f_r       <= f_nxt;
    out_xor_r <= out_xor_nxt;
    out_err_r <= out_err_nxt;
  end
endmodule
`default_nettype wire

FILE: rtl/rxq_ram.sv
// Single-port synchronous RAM holding the two parity-split prefix trees.
`timescale 1ns / 1ps
`default_nettype none
module rxq_ram #(
  parameter int ADDR_BITS = 12
) (
  input  wire                    clk,
  input  wire                    we,
  input  wire [ADDR_BITS-1:0]    addr,
  input  wire rxq_pkg::data_t    wdata,
  output rxq_pkg::data_t         rdata
);
  rxq_pkg::data_t mem [2**ADDR_BITS];
  rxq_pkg::data_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

FILE: verif/range_xor_update_query_tree_unit_test.sv
// Self-checking testbench for the range XOR update and query unit.
`timescale 1ns / 1ps
module range_xor_update_query_tree_unit_test;
  localparam int NUM_ELEMS = 1024;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic           op;
    rxq_pkg::idx_t  lo;
    rxq_pkg::idx_t  hi;
    rxq_pkg::data_t value;
  } req_t;

  typedef struct packed {
    rxq_pkg::data_t xor_sum;
    logic           bad;
  } resp_t;

  // One directed row: the request, whether the answer is typed in, and that answer.
  typedef struct packed {
    req_t  req;
    logic  has_ans;
    resp_t ans;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  range_xor_update_query_tree_unit #(.MAX_ELEMENTS(NUM_ELEMS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("[range_xor_update_query_tree_unit] ERROR");
    $finish;
  end

  // The predictor keeps the plain element array; the tree shape inside the
  // block is irrelevant to the answers, so a flat array is exact.
  rxq_pkg::data_t elem_shadow [NUM_ELEMS];
  logic [10:0]    count_shadow;
  resp_t          pending_answers[$];
  int             error_count = 0;
  logic           hold_off = 1'b0;

  function automatic logic range_flagged(req_t r);
    int lim;
    lim = (count_shadow > NUM_ELEMS) ? NUM_ELEMS : count_shadow;
    return (r.lo > r.hi) || (int'(r.hi) >= lim);
  endfunction

  // Applies a request to the shadow array and queues the answer of a query.
  task automatic predict_word(req_t r);
    resp_t a;
    logic  bad;
    bad = range_flagged(r);
    if (r.op == rxq_pkg::OP_UPDATE) begin
      if (!bad)
        for (int i = r.lo; i <= r.hi; i++) elem_shadow[i] ^= r.value;
    end else begin
      a.bad = bad;
      a.xor_sum = '0;
      if (!bad)
        for (int i = r.lo; i <= r.hi; i++) a.xor_sum ^= elem_shadow[i];
      pending_answers.push_back(a);
    end
  endtask

  // Sends one word; the sender drives at the falling edge and waits for the
  // handshake at the rising edge.
  task automatic send_word(req_t r);
    in_tdata  <= {3'b0, r.value, r.hi, r.lo, r.op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_word(r);
    @(negedge clk);
  endtask

  task automatic send_gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(logic [10:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    count_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Checker: every accepted result word is compared against the oldest answer.
  always @(posedge clk) begin
    resp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.xor_sum = out_tdata[31:0];
      got.bad = out_tdata[32];
      if (pending_answers.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected xor %h err %b, got xor %h err %b",
                     want.xor_sum, want.bad, got.xor_sum, got.bad);
        end
      end
    end
  end

  // Receiver stalls on its own pattern; hold_off forces a long back-pressure stretch.
  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 9) < 7);
  end

  function automatic req_t make_req(logic op, int lo, int hi, rxq_pkg::data_t v);
    req_t r;
    r.op = op;
    r.lo = rxq_pkg::idx_t'(lo);
    r.hi = rxq_pkg::idx_t'(hi);
    r.value = v;
    return r;
  endfunction

  // Random word: mostly valid ranges inside the count, some flagged ones.
  function automatic req_t random_req();
    req_t r;
    int lim, a, b, t;
    lim = (count_shadow > NUM_ELEMS) ? NUM_ELEMS : count_shadow;
    r.op = 1'($urandom_range(0, 1));
    r.value = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      r.lo = rxq_pkg::idx_t'($urandom());
      r.hi = rxq_pkg::idx_t'($urandom());
    end else begin
      a = $urandom_range(0, lim - 1);
      b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim - 1)
                                     : a + $urandom_range(0, 15);
      if (b > lim - 1) b = lim - 1;
      if (a > b) begin t = a; a = b; b = t; end
      r.lo = rxq_pkg::idx_t'(a);
      r.hi = rxq_pkg::idx_t'(b);
    end
    return r;
  endfunction

  task automatic random_phase(int words);
    int burst;
    while (words > 0) begin
      burst = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 12);
      for (int k = 0; k < burst && words > 0; k++) begin
        send_word(random_req());
        words--;
      end
      send_gap();
    end
  endtask

  dir_row_t dir_rows[$];
  resp_t    zero_ok, flag_ans;

  initial begin
    foreach (elem_shadow[i]) elem_shadow[i] = '0;
    count_shadow = 11'd1024;
    zero_ok = '{xor_sum: '0, bad: 1'b0};
    flag_ans = '{xor_sum: '0, bad: 1'b1};

    // Directed table: answers typed in where obvious, else left to the predictor.
    dir_rows.push_back('{make_req(rxq_pkg::OP_QUERY, 0, 1023, '0), 1'b1, zero_ok});
    dir_rows.push_back('{make_req(rxq_pkg::OP_QUERY, 0, 0, '0), 1'b1, zero_ok});
    dir_rows.push_back('{make_req(rxq_pkg::OP_QUERY, 5, 4, '0), 1'b1, flag_ans});
    dir_rows.push_back('{make_req(rxq_pkg::OP_UPDATE, 0, 0, 32'hFFFF_FFFF), 1'b0, '0});
    dir_rows.push_back('{make_req(rxq_pkg::OP_UPDATE, 1023, 1023, 32'h8000_0001),
                         1'b0, '0});
    dir_rows.push_back('{make_req(rxq_pkg::OP_UPDATE, 0, 1023, 32'h5A5A_A5A5), 1'b0, '0});
    dir_rows.push_back('{make_req(rxq_pkg::OP_UPDATE, 9, 3, 32'h1234_5678), 1'b0, '0});
    dir_rows.push_back('{make_req(rxq_pkg::OP_QUERY, 0, 0, '0), 1'b0, '0});
    dir_rows.push_back('{make_req(rxq_pkg::OP_QUERY, 1023, 1023, '0), 1'b0, '0});
    dir_rows.push_back('{make_req(rxq_pkg::OP_QUERY, 0, 1023, '0), 1'b0, '0});
    dir_rows.push_back('{make_req(rxq_pkg::OP_QUERY, 1, 1022, '0), 1'b0, '0});
    dir_rows.push_back('{make_req(rxq_pkg::OP_QUERY, 1023, 0, '0), 1'b1, flag_ans});
    dir_rows.push_back('{make_req(rxq_pkg::OP_UPDATE, 100, 611, 32'h0F0F_0F0F), 1'b0, '0});
    dir_rows.push_back('{make_req(rxq_pkg::OP_QUERY, 99, 612, '0), 1'b0, '0});
    dir_rows.push_back('{make_req(rxq_pkg::OP_QUERY, 3, 9, '0), 1'b0, '0});

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    write_count(11'd1024);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].req);
      if (dir_rows[i].has_ans) pending_answers[$] = dir_rows[i].ans;
    end
    drain_and_settle();

    // Small count: indexes past it are flagged, stored values kept.
    write_count(11'd1);
    send_word(make_req(rxq_pkg::OP_QUERY, 0, 0, '0));
    send_word(make_req(rxq_pkg::OP_QUERY, 0, 1, '0));
    send_word(make_req(rxq_pkg::OP_UPDATE, 1, 1, 32'hDEAD_BEEF));
    random_phase(60);
    drain_and_settle();

    // Count of zero flags everything; count above capacity acts as capacity.
    write_count(11'd0);
    send_word(make_req(rxq_pkg::OP_QUERY, 0, 0, '0));
    send_word(make_req(rxq_pkg::OP_UPDATE, 0, 0, 32'hFFFF_FFFF));
    drain_and_settle();
    write_count(11'd2047);
    send_word(make_req(rxq_pkg::OP_QUERY, 0, 1023, '0));

    // Long receiver hold-off while the sender keeps offering words.
    hold_off = 1'b1;
    fork
      begin
        repeat (2000) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 20; k++)
        send_word(make_req(rxq_pkg::OP_QUERY, $urandom_range(0, 511),
                           $urandom_range(512, 1023), '0));
    join
    random_phase(200);
    drain_and_settle();

    write_count(11'd37);
    random_phase(140);
    drain_and_settle();

    write_count(11'd1024);
    random_phase(200);
    drain_and_settle();

    if (error_count == 0) begin
      $display("[range_xor_update_query_tree_unit] OK");
    end else begin
      $display("[range_xor_update_query_tree_unit] ERROR");
    end
    $finish;
  end
endmodule
